// ===== hw/rtl/ircm_pkg.sv =====
package ircm_pkg;

    // Field widths of the streaming ports.
    localparam int SPACE_W  = 20;
    localparam int UNITS_W  = 8;
    localparam int KIND_W   = 2;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;

    // Default build values.
    localparam int HIST_DEPTH_DEF = 64;
    localparam int UNIT_US_DEF    = 560;
    localparam int CODE_LEN_DEF   = 32;

    typedef logic [UNITS_W-1:0] units_t;

    // Pattern values in base units.
    localparam units_t HEADER_UNITS = 8'd8;
    localparam units_t REPEAT_LEAD  = 8'd4;
    localparam units_t REPEAT_TAIL  = 8'd172;

    // Minimum unit counts of the recognized button code; entry 0 is the header.
    localparam units_t CODE_MIN [0:31] = '{
        8'd8, 8'd1, 8'd1, 8'd3, 8'd3, 8'd1, 8'd3, 8'd3,
        8'd1, 8'd1, 8'd1, 8'd1, 8'd3, 8'd1, 8'd3, 8'd3,
        8'd1, 8'd1, 8'd3, 8'd3, 8'd1, 8'd3, 8'd1, 8'd3,
        8'd1, 8'd3, 8'd1, 8'd1, 8'd3, 8'd1, 8'd3, 8'd1
    };

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE   = 2'd0,
        KIND_CODE   = 2'd1,
        KIND_REPEAT = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QUANT,
        ST_WRITE,
        ST_START,
        ST_SCAN,
        ST_DONE
    } state_t;

    // What the word returning from the history memory is checked as.
    typedef enum logic [1:0] {
        PH_HEAD,
        PH_CODE,
        PH_TAIL
    } phase_t;

endpackage

// ===== hw/rtl/ir_space_code_matcher_unit.sv =====
// IR space code matcher.
// Slave channel: one word per measured IR space, s_tdata[19:0] in microseconds.
// Master channel: one word per input word; m_tdata[7:0] is the space rounded to
// base units (saturated at 255), m_tuser[1:0] says whether the history now holds
// a button code (1), a repeat code (2) or neither (0).
// The block handles one word at a time. Rounding is one multiplication by the
// reciprocal of UNIT_US. The history memory is then written and scanned one
// memory read per cycle over the start positions 0 .. HIST_DEPTH-34. A position
// costs one read, a repeat lead two, a header up to CODE_LEN, and a match ends
// the scan early. The scan is bounded by the single read port.
// s_tready is high only while no word is being worked on. A finished result
// waits in the output register while m_tready is low; a new input word is
// still taken then, and its result is held until the register is free.
// On a match the whole history is dropped and the write pointer returns to 0.
// Reset (aresetn low at a clock edge) empties the history and the output
// register at once; no clearing pass is needed.
module ir_space_code_matcher_unit #(
    parameter int HIST_DEPTH = ircm_pkg::HIST_DEPTH_DEF,
    parameter int UNIT_US    = ircm_pkg::UNIT_US_DEF,
    parameter int CODE_LEN   = ircm_pkg::CODE_LEN_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ircm_pkg::S_TDATA_W-1:0] s_tdata,   // [19:0] space_us
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ircm_pkg::M_TDATA_W-1:0] m_tdata,   // [7:0] units
    output logic [ircm_pkg::KIND_W-1:0]    m_tuser    // [1:0] match_kind
);
    import ircm_pkg::*;

    localparam int AW    = $clog2(HIST_DEPTH);
    localparam int DW    = SPACE_W + 1;
    localparam int SHIFT = DW + $clog2(UNIT_US);
    localparam int OW    = $clog2(CODE_LEN);
    localparam logic [DW:0]   RECIP    =
        (DW + 1)'(((64'd1 << SHIFT) + 64'(UNIT_US - 1)) / 64'(UNIT_US));
    localparam logic [AW-1:0] LAST_POS = AW'(HIST_DEPTH - 34);
    localparam logic [AW-1:0] LAST_WP  = AW'(HIST_DEPTH - 1);
    localparam logic [OW-1:0] LAST_OFF = OW'(CODE_LEN - 1);

    state_t                state_reg, state_next;
    phase_t                phase_reg, phase_next;
    logic [DW-1:0]         div_reg, div_next;
    logic [DW-1:0]         quot_reg, quot_next;
    units_t                units_reg, units_next;
    logic [AW-1:0]         wp_reg, wp_next;
    logic [HIST_DEPTH-1:0] valid_reg, valid_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic [OW-1:0]         off_reg, off_next;
    logic [AW-1:0]         nxt_addr_reg, nxt_addr_next;
    kind_t                 kind_reg, kind_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    kind_t                 m_kind_reg, m_kind_next;
    units_t                m_units_reg, m_units_next;

    units_t                hist_mem [HIST_DEPTH];
    units_t                rd_data_reg;
    logic                  rd_vld_reg;
    logic [AW-1:0]         issue_addr;
    logic                  mem_we;
    units_t                units_sat;
    units_t                hval;
    logic [2*DW:0]         product;
    logic                  out_load;

    // Saturated quotient and the history word as seen by the scan.
    assign units_sat = (|quot_reg[DW-1:UNITS_W]) ? '1 : quot_reg[UNITS_W-1:0];
    assign hval      = rd_vld_reg ? rd_data_reg : '0;

    // The reciprocal is rounded up, which makes the truncated quotient exact
    // for every dividend that fits in DW bits.
    assign product   = div_reg * RECIP;

    // History memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hist_mem[wp_reg] <= units_sat;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= hist_mem[issue_addr];
        rd_vld_reg  <= valid_reg[issue_addr];
    end

    // Sequencer: divide, write, scan, deliver.
    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        div_next      = div_reg;
        quot_next     = quot_reg;
        units_next    = units_reg;
        wp_next       = wp_reg;
        valid_next    = valid_reg;
        pos_next      = pos_reg;
        off_next      = off_reg;
        kind_next     = kind_reg;
        m_tvalid_next = m_tvalid_reg;
        m_kind_next   = m_kind_reg;
        m_units_next  = m_units_reg;
        issue_addr    = nxt_addr_reg;
        mem_we        = 1'b0;
        s_tready      = 1'b0;
        out_load      = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    div_next   = DW'(s_tdata[SPACE_W-1:0]) + DW'(UNIT_US / 2);
                    quot_next  = '0;
                    state_next = ST_QUANT;
                end
            end
            ST_QUANT: begin
                // Divide by UNIT_US through the reciprocal in one step.
                quot_next  = DW'(product >> SHIFT);
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                mem_we             = 1'b1;
                units_next         = units_sat;
                valid_next[wp_reg] = 1'b1;
                wp_next            = (wp_reg == LAST_WP) ? '0 : wp_reg + 1'b1;
                state_next         = ST_START;
            end
            ST_START: begin
                issue_addr = '0;
                pos_next   = '0;
                off_next   = '0;
                phase_next = PH_HEAD;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                unique case (phase_reg)
                    PH_HEAD: begin
                        if (hval == HEADER_UNITS) begin
                            phase_next = PH_CODE;
                            off_next   = OW'(1);
                        end else if (hval == REPEAT_LEAD) begin
                            phase_next = PH_TAIL;
                        end else if (pos_reg == LAST_POS) begin
                            kind_next  = KIND_NONE;
                            state_next = ST_DONE;
                        end else begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                    PH_CODE: begin
                        if (hval >= CODE_MIN[5'(off_reg)]) begin
                            if (off_reg == LAST_OFF) begin
                                kind_next  = KIND_CODE;
                                state_next = ST_DONE;
                            end else begin
                                off_next = off_reg + 1'b1;
                            end
                        end else if (pos_reg == LAST_POS) begin
                            kind_next  = KIND_NONE;
                            state_next = ST_DONE;
                        end else begin
                            // Restart at the next position.
                            issue_addr = pos_reg + 1'b1;
                            pos_next   = pos_reg + 1'b1;
                            phase_next = PH_HEAD;
                        end
                    end
                    PH_TAIL: begin
                        if (hval == REPEAT_TAIL) begin
                            kind_next  = KIND_REPEAT;
                            state_next = ST_DONE;
                        end else if (pos_reg == LAST_POS) begin
                            kind_next  = KIND_NONE;
                            state_next = ST_DONE;
                        end else begin
                            issue_addr = pos_reg + 1'b1;
                            pos_next   = pos_reg + 1'b1;
                            phase_next = PH_HEAD;
                        end
                    end
                    default: begin
                        phase_next = PH_HEAD;
                    end
                endcase
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load      = 1'b1;
                    m_tvalid_next = 1'b1;
                    m_kind_next   = kind_reg;
                    m_units_next  = units_reg;
                    if (kind_reg != KIND_NONE) begin
                        valid_next = '0;
                        wp_next    = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        nxt_addr_next = issue_addr + 1'b1;
    end

    // Control and payload registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_HEAD;
            wp_reg       <= '0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            kind_reg     <= KIND_NONE;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            wp_reg       <= wp_next;
            valid_reg    <= valid_next;
            m_tvalid_reg <= m_tvalid_next;
            kind_reg     <= kind_next;
        end
        div_reg      <= div_next;
        quot_reg     <= quot_next;
        units_reg    <= units_next;
        pos_reg      <= pos_next;
        off_reg      <= off_next;
        nxt_addr_reg <= nxt_addr_next;
        m_kind_reg   <= m_kind_next;
        m_units_reg  <= m_units_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_units_reg;
    assign m_tuser  = m_kind_reg;

`ifndef SYNTHESIS
    // A reported match leaves an empty history with the pointer at the start.
    a_match_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && (kind_reg != KIND_NONE) |=> (wp_reg == '0) && (valid_reg == '0))
        else $error("history not cleared after a match");

    // The scan never examines a start position past the last one.
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (pos_reg <= LAST_POS))
        else $error("scan position out of range");

    // A button code is only reported after its last code entry was checked.
    a_code_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) && (state_next == ST_DONE) && (kind_next == KIND_CODE)
        |-> (phase_reg == PH_CODE) && (off_reg == LAST_OFF))
        else $error("button code reported before all entries were checked");

    // The output register is loaded only when free or being drained.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("pending result overwritten");
`endif

endmodule
